### hdl/ffa_pkg.sv
// shared types, widths and codes for the first-fit slot allocator
// no dependencies; imported by every other file of the block except ffa_map_ram
`default_nettype none

package ffa_pkg;

  localparam int VREG_W   = 10;
  localparam int SLOT_W   = 6;
  localparam int STATUS_W = 2;
  localparam int ACT_W    = 7;

  localparam int NUM_SLOTS_DEF = 64;
  localparam int NUM_VREGS_DEF = 1024;

  localparam logic [ACT_W-1:0] ACTIVE_RESET = ACT_W'(64);

  // fixed-point shift of the reciprocal used to fold vreg into the map depth
  localparam int FOLD_SHIFT = 20;
  localparam int RECIP_W    = 17;

  typedef enum logic {
    REQ_BIRTH = 1'b0,
    REQ_DEATH = 1'b1
  } req_type_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_MAPPED   = 2'd1,
    STAT_UNMAPPED = 2'd2,
    STAT_FULL     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FOLD,
    S_LOOKUP,
    S_DECIDE
  } state_e;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
  } pick_t;

endpackage

`default_nettype wire

### hdl/ffa_intf.sv
// request and response channel interfaces of the slot allocator
// depends on ffa_pkg for the field widths
`default_nettype none

interface ffa_req_if;
  import ffa_pkg::*;

  logic              valid;
  logic              ready;
  logic              req_type;
  logic [VREG_W-1:0] vreg;

  modport source (output valid, output req_type, output vreg, input ready);
  modport sink   (input valid, input req_type, input vreg, output ready);
endinterface

interface ffa_rsp_if;
  import ffa_pkg::*;

  logic                valid;
  logic                ready;
  logic [SLOT_W-1:0]   slot;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output slot, output status, input ready);
  modport sink   (input valid, input slot, input status, output ready);
endinterface

`default_nettype wire

### hdl/ffa_map_ram.sv
// single-port-write, registered-read memory holding the vreg to slot map
// depends on nothing but its parameters
`default_nettype none

module ffa_map_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 7
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

### hdl/ffa_free_enc.sv
// lowest free slot below the active limit, from the busy bitmap
// depends on ffa_pkg for pick_t and widths
`default_nettype none

module ffa_free_enc #(
  parameter int NUM_SLOTS = ffa_pkg::NUM_SLOTS_DEF
) (
  input  wire logic [NUM_SLOTS-1:0]     busy_i,
  input  wire logic [ffa_pkg::ACT_W-1:0] limit_i,
  output ffa_pkg::pick_t                pick_o
);
  import ffa_pkg::*;

  logic [NUM_SLOTS-1:0] free;
  logic [NUM_SLOTS-1:0] lowest;
  logic [SLOT_W-1:0]    enc;

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      free[i] = !busy_i[i] && (ACT_W'(i) < limit_i);
    end
  end

  // isolate the lowest set bit, then or-encode the one-hot vector
  assign lowest = free & (~free + NUM_SLOTS'(1));

  always_comb begin
    enc = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (lowest[i]) begin
        enc = enc | SLOT_W'(i);
      end
    end
  end

  assign pick_o.found = |free;
  assign pick_o.slot  = enc;

endmodule

`default_nettype wire

### hdl/first_fit_register_slot_allocator_unit.sv
// first-fit register slot allocator: one beat in flight
// an accepted request beat passes the fold, lookup and decide states; decide loads the
// response register once the response channel is free, and only then is a new request taken
// after reset a clearing pass zeroes every map entry, no request taken
// reset: busy bitmap cleared, active limit back to 64, response channel empty
// depends on ffa_pkg, ffa_intf, ffa_map_ram and ffa_free_enc
`default_nettype none

module first_fit_register_slot_allocator_unit #(
  parameter int NUM_SLOTS = ffa_pkg::NUM_SLOTS_DEF,
  parameter int NUM_VREGS = ffa_pkg::NUM_VREGS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [ffa_pkg::ACT_W-1:0] cfg_wdata_i,
  ffa_req_if.sink                        req_i,
  ffa_rsp_if.source                      rsp_o
);
  import ffa_pkg::*;

  localparam int SIDX_W = $clog2(NUM_SLOTS);
  localparam int VIDX_W = $clog2(NUM_VREGS);
  localparam int MAP_W  = 1 + SIDX_W;
  localparam int MUL_W  = VREG_W + RECIP_W;
  // floor reciprocal: estimate of vreg / NUM_VREGS is low by at most one
  localparam int RECIP  = (1 << FOLD_SHIFT) / NUM_VREGS;

  localparam logic [VIDX_W-1:0] CLR_LAST = VIDX_W'(NUM_VREGS - 1);
  localparam logic [MUL_W-1:0]  DEPTH_W  = MUL_W'(NUM_VREGS);

  // control state
  state_e               state_q, state_d;
  logic [VIDX_W-1:0]    clr_idx_q;
  logic [NUM_SLOTS-1:0] busy_q;
  logic [ACT_W-1:0]     active_q;
  logic                 rsp_valid_q;

  // per-beat payload registers
  req_type_e            type_q;
  logic [VREG_W-1:0]    vreg_q;
  logic [VREG_W-1:0]    quot_q;
  logic [VIDX_W-1:0]    vidx_q;
  logic [SLOT_W-1:0]    rsp_slot_q;
  status_e              rsp_status_q;

  // fsm outputs
  logic req_ready;
  logic map_re;
  logic load;

  // decide step
  logic                 out_free;
  logic [MAP_W-1:0]     map_rdata;
  logic                 map_valid;
  logic [SIDX_W-1:0]    map_slot;
  pick_t                pick;
  logic                 alloc_ok;
  logic                 release_ok;
  status_e              res_status;
  logic [SLOT_W-1:0]    res_slot;

  // fold of vreg into the map depth
  logic [MUL_W-1:0]     prod;
  logic [MUL_W-1:0]     quot_n;
  logic [MUL_W-1:0]     rest_raw;
  logic [MUL_W-1:0]     rest_fix;
  logic [VIDX_W-1:0]    vidx;

  // map memory ports
  logic                 map_we;
  logic [VIDX_W-1:0]    map_waddr;
  logic [MAP_W-1:0]     map_wdata;

  assign out_free = !rsp_valid_q || rsp_o.ready;

  // ---------------------------------------------------------------- fsm
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_idx_q == CLR_LAST) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_i.valid) begin
          state_d = S_FOLD;
        end
      end
      S_FOLD:   state_d = S_LOOKUP;
      S_LOOKUP: state_d = S_DECIDE;
      S_DECIDE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    map_re    = 1'b0;
    load      = 1'b0;
    unique case (state_q)
      S_IDLE:   req_ready = 1'b1;
      S_LOOKUP: map_re    = 1'b1;
      S_DECIDE: load      = out_free;
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  assign req_i.ready = req_ready;

  // ---------------------------------------------------------------- vreg fold
  // quotient estimate in the fold cycle, remainder and one correction in lookup
  assign prod     = MUL_W'(vreg_q) * MUL_W'(RECIP);
  assign quot_n   = MUL_W'(quot_q) * DEPTH_W;
  assign rest_raw = MUL_W'(vreg_q) - quot_n;
  assign rest_fix = (rest_raw >= DEPTH_W) ? (rest_raw - DEPTH_W) : rest_raw;
  assign vidx     = rest_fix[VIDX_W-1:0];

  // ---------------------------------------------------------------- map memory
  // one beat in flight: the write-back in decide always lands before the next read
  assign map_we    = (state_q == S_CLEAR) || (load && alloc_ok);
  assign map_waddr = (state_q == S_CLEAR) ? clr_idx_q : vidx_q;
  assign map_wdata = (state_q == S_CLEAR) ? '0 : {1'b1, pick.slot[SIDX_W-1:0]};

  ffa_map_ram #(
    .DEPTH (NUM_VREGS),
    .AW    (VIDX_W),
    .DW    (MAP_W)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .re_i    (map_re),
    .raddr_i (vidx),
    .rdata_o (map_rdata)
  );

  assign map_valid = map_rdata[MAP_W-1];
  assign map_slot  = map_rdata[SIDX_W-1:0];

  // ---------------------------------------------------------------- free slot search
  ffa_free_enc #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_free_enc (
    .busy_i  (busy_q),
    .limit_i (active_q),
    .pick_o  (pick)
  );

  // ---------------------------------------------------------------- decide
  always_comb begin
    alloc_ok   = 1'b0;
    release_ok = 1'b0;
    res_status = STAT_OK;
    res_slot   = '0;
    unique case (type_q)
      REQ_BIRTH: begin
        if (map_valid) begin
          res_status = STAT_MAPPED;
        end else if (!pick.found) begin
          res_status = STAT_FULL;
        end else begin
          alloc_ok = 1'b1;
          res_slot = pick.slot;
        end
      end
      REQ_DEATH: begin
        if (!map_valid) begin
          res_status = STAT_UNMAPPED;
        end else begin
          // repeated death frees the same slot again, as a death leaves the map entry set
          release_ok = 1'b1;
          res_slot   = SLOT_W'(map_slot);
        end
      end
      default: begin
        res_status = STAT_OK;
      end
    endcase
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_idx_q   <= '0;
      busy_q      <= '0;
      active_q    <= ACTIVE_RESET;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_idx_q <= clr_idx_q + VIDX_W'(1);
      end
      if (cfg_we_i) begin
        active_q <= cfg_wdata_i;
      end
      if (load && alloc_ok) begin
        busy_q[pick.slot[SIDX_W-1:0]] <= 1'b1;
      end
      if (load && release_ok) begin
        busy_q[map_slot] <= 1'b0;
      end
      if (load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_ready) begin
      type_q <= req_type_e'(req_i.req_type);
      vreg_q <= req_i.vreg;
    end
    if (state_q == S_FOLD) begin
      quot_q <= VREG_W'(prod >> FOLD_SHIFT);
    end
    if (state_q == S_LOOKUP) begin
      vidx_q <= vidx;
    end
    if (load) begin
      rsp_slot_q   <= res_slot;
      rsp_status_q <= res_status;
    end
  end

  assign rsp_o.valid  = rsp_valid_q;
  assign rsp_o.slot   = rsp_slot_q;
  assign rsp_o.status = rsp_status_q;

  // ---------------------------------------------------------------- assertions
  a_no_req_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !req_i.ready)
    else $error("request taken during map clearing pass");

  a_accept_starts_fold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> (state_q == S_FOLD))
    else $error("accepted beat did not enter the fold step");

  a_error_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status != STAT_OK)) |-> (rsp_o.slot == '0))
    else $error("error response carries a nonzero slot");

  a_alloc_marks_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && alloc_ok) |=> busy_q[$past(pick.slot[SIDX_W-1:0])])
    else $error("allocated slot not marked busy");

endmodule

`default_nettype wire

### dv/slot_grant_checker.sv
// checker for the first-fit slot allocator: predicts each response from the request beats
// and the limit writes it sees, and compares it with the response beats
// depends on ffa_pkg and ffa_intf
module slot_grant_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [ffa_pkg::ACT_W-1:0] cfg_wdata_i,
  ffa_req_if                        req,
  ffa_rsp_if                        rsp,
  output int                        fail_cnt,
  output int                        pending
);
  import ffa_pkg::*;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    status_e           status;
  } grant_t;

  logic [ACT_W-1:0]  slot_limit;
  bit                busy  [NUM_SLOTS_DEF];
  bit                bound [NUM_VREGS_DEF];
  logic [SLOT_W-1:0] home  [NUM_VREGS_DEF];
  grant_t            grant_q [$];
  grant_t            want;
  int                errs;

  // lowest free slot under the saturated limit on a birth, the mapped slot on a death
  function automatic grant_t predict_grant(input req_type_e kind, input logic [VREG_W-1:0] vr);
    grant_t g;
    int     lim;
    int     pick;
    g.slot   = '0;
    g.status = STAT_OK;
    lim      = (int'(slot_limit) > NUM_SLOTS_DEF) ? NUM_SLOTS_DEF : int'(slot_limit);
    if (kind == REQ_BIRTH) begin
      if (bound[vr]) begin
        g.status = STAT_MAPPED;
      end else begin
        pick = -1;
        for (int i = lim - 1; i >= 0; i--) begin
          if (!busy[i]) pick = i;
        end
        if (pick < 0) begin
          g.status = STAT_FULL;
        end else begin
          busy[pick] = 1'b1;
          bound[vr]  = 1'b1;
          home[vr]   = SLOT_W'(pick);
          g.slot     = SLOT_W'(pick);
        end
      end
    end else begin
      if (!bound[vr]) begin
        g.status = STAT_UNMAPPED;
      end else begin
        g.slot         = home[vr];
        busy[home[vr]] = 1'b0;
      end
    end
    return g;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_limit = ACTIVE_RESET;
      for (int i = 0; i < NUM_SLOTS_DEF; i++) busy[i] = 1'b0;
      for (int i = 0; i < NUM_VREGS_DEF; i++) bound[i] = 1'b0;
      grant_q.delete();
    end else begin
      if (cfg_we_i) slot_limit = cfg_wdata_i;
      if (req.valid === 1'b1 && req.ready === 1'b1) begin
        grant_q = {grant_q, predict_grant(req_type_e'(req.req_type), req.vreg)};
      end
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
        if (grant_q.size() == 0) begin
          errs++;
          $display("%0t unexpected response beat: slot %0d status %0d", $time,
                   rsp.slot, rsp.status);
        end else begin
          want = grant_q.pop_front();
          if (rsp.slot !== want.slot) begin
            errs++;
            $display("%0t slot mismatch: expected %0d got %0d", $time, want.slot, rsp.slot);
          end
          if (rsp.status !== want.status) begin
            errs++;
            $display("%0t status mismatch: expected %0d got %0d", $time,
                     want.status, rsp.status);
          end
        end
      end
    end
    pending  <= grant_q.size();
    fail_cnt <= errs;
  end

endmodule

### dv/tb.sv
// top of the slot allocator testbench: clock, reset, limit writes, request and response traffic
// depends on ffa_pkg, ffa_intf, first_fit_register_slot_allocator_unit and slot_grant_checker
module tb;
  import ffa_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  // extra settling wait in quiesce, after the last predicted response has come back
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_BEATS  = 315;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [ACT_W-1:0] cfg_wdata_i;

  int send_idle_pct;
  int stall_pct;
  int cycles;
  int fail_cnt;
  int pending;

  // stimulus bookkeeping only: which vregs were ever born, and which are thought live
  bit                taken [NUM_VREGS_DEF];
  int                taken_cnt;
  logic [VREG_W-1:0] live_q [$];
  logic [VREG_W-1:0] born_q [$];

  // mostly small limits so that the slot map fills up, plus the wide ones
  int phase_limit [6] = '{7, 64, 127, 1, 24, 3};

  ffa_req_if req_if ();
  ffa_rsp_if rsp_if ();

  first_fit_register_slot_allocator_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  slot_grant_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req         (req_if),
    .rsp         (rsp_if),
    .fail_cnt    (fail_cnt),
    .pending     (pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // response side back-pressure
  always @(posedge clk_i) begin
    rsp_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // one request beat, with random idle cycles ahead of it; valid stays high afterwards
  // so back-to-back beats never lower and raise it in the same step
  task automatic send_beat(input req_type_e kind, input logic [VREG_W-1:0] vr);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= kind;
    req_if.vreg     <= vr;
    if (kind == REQ_BIRTH && !taken[vr]) begin
      taken[vr] = 1'b1;
      taken_cnt++;
      born_q = {born_q, vr};
    end
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
  endtask

  // stop sending until every predicted response has come back, then let the block settle
  task automatic quiesce();
    req_if.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [ACT_W-1:0] lim);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= lim;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // mostly well-formed lifetimes: births of fresh vregs and deaths of live ones,
  // then revisits of old vregs (mapped births, repeated deaths) and raw noise
  task automatic random_beat();
    int                pick;
    int                probe;
    logic [VREG_W-1:0] vr;
    pick = $urandom_range(99);
    if (pick < 35 && taken_cnt < NUM_VREGS_DEF) begin
      probe = $urandom_range(NUM_VREGS_DEF - 1);
      while (taken[probe]) probe = (probe + 1) % NUM_VREGS_DEF;
      live_q = {live_q, VREG_W'(probe)};
      send_beat(REQ_BIRTH, VREG_W'(probe));
    end else if (pick < 65 && live_q.size() > 0) begin
      probe = $urandom_range(live_q.size() - 1);
      vr    = live_q[probe];
      live_q.delete(probe);
      send_beat(REQ_DEATH, vr);
    end else if (pick < 80 && born_q.size() > 0) begin
      vr = born_q[$urandom_range(born_q.size() - 1)];
      send_beat(req_type_e'($urandom_range(1)), vr);
    end else begin
      send_beat(req_type_e'($urandom_range(1)), VREG_W'($urandom_range(NUM_VREGS_DEF - 1)));
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = ACTIVE_RESET;
    req_if.valid    = 1'b0;
    req_if.req_type = REQ_BIRTH;
    req_if.vreg     = '0;
    send_idle_pct   = 0;
    stall_pct       = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // the map clearing pass after reset holds off requests
    do @(posedge clk_i); while (req_if.ready !== 1'b1);

    // two slots: fill, overflow, mapped birth, unmapped death, repeated death
    write_limit(ACT_W'(2));
    send_beat(REQ_BIRTH, 10'd0);
    send_beat(REQ_BIRTH, 10'd1023);
    send_beat(REQ_BIRTH, 10'd5);
    send_beat(REQ_BIRTH, 10'd0);
    send_beat(REQ_DEATH, 10'd7);
    send_beat(REQ_DEATH, 10'd0);
    send_beat(REQ_DEATH, 10'd0);
    send_beat(REQ_BIRTH, 10'd5);
    send_beat(REQ_BIRTH, 10'd682);
    quiesce();

    // zero limit: births all fail, deaths still free slots above the limit,
    // and a dead register still counts as mapped
    write_limit(ACT_W'(0));
    send_beat(REQ_BIRTH, 10'd341);
    send_beat(REQ_DEATH, 10'd1023);
    send_beat(REQ_BIRTH, 10'd1023);
    send_beat(REQ_DEATH, 10'd5);
    send_beat(REQ_DEATH, 10'd682);
    quiesce();

    // limit above the slot count saturates
    write_limit(ACT_W'(127));
    send_beat(REQ_BIRTH, 10'd341);
    send_beat(REQ_BIRTH, 10'd682);
    send_beat(REQ_BIRTH, 10'd512);
    send_beat(REQ_DEATH, 10'd682);
    send_beat(REQ_BIRTH, 10'd1);
    send_beat(REQ_DEATH, 10'd341);
    quiesce();

    // limit lowered under live slots: their deaths still free them
    write_limit(ACT_W'(1));
    send_beat(REQ_BIRTH, 10'd2);
    send_beat(REQ_BIRTH, 10'd3);
    send_beat(REQ_DEATH, 10'd512);

    // random phases; idling goes sender-light, then receiver-light, then none
    for (int ph = 0; ph < 6; ph++) begin
      quiesce();
      write_limit(ACT_W'(phase_limit[ph]));
      case (ph / 2)
        0: begin
          send_idle_pct = 13;
          stall_pct    <= 86;
        end
        1: begin
          send_idle_pct = 86;
          stall_pct    <= 13;
        end
        default: begin
          send_idle_pct = 0;
          stall_pct    <= 0;
        end
      endcase
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if ($urandom_range(149) == 0) quiesce();
        random_beat();
      end
    end

    quiesce();
    @(negedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### files.f
hdl/ffa_pkg.sv
hdl/ffa_intf.sv
hdl/ffa_map_ram.sv
hdl/ffa_free_enc.sv
hdl/first_fit_register_slot_allocator_unit.sv
dv/slot_grant_checker.sv
dv/tb.sv
